>>> rtl/core/kcio_pkg.sv
// shared constants and command/status types for the keyed cache
`default_nettype none

package kcio_pkg;

  // default sizing
  localparam int unsigned ENTRIES_DEF     = 16;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MODE_BITS  = 2;
  localparam int unsigned LIMIT_BITS = 5;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  // operation codes
  localparam logic [MODE_BITS-1:0] MODE_GET   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

  // register index (paddr word select) and reset value
  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic [LIMIT_BITS-1:0] MAX_ENTRIES_RST = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic look;
    logic exec;
    logic deliver;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage : kcio_pkg

`default_nettype wire

>>> rtl/core/keyed_cache_insert_order_evict.sv
// keyed cache top level: configuration port, controller and datapath
//
//   channel  direction  handshake             payload
//   in       request in  in_valid_i/in_stall_o  mode_i key_i store_value_i
//   out      result out  out_valid_o/out_stall_i hit_o read_value_o evicted_o evicted_key_o
//   cfg      apb slave  psel/penable/pready   paddr pwdata prdata
//
// an accepted request passes key compare, table update and result hand-over in turn
// before its result is registered; the hand-over waits while the output is stalled.
// the next request is taken in the cycle after the hand-over, not before the last one is through.
// the registered key compare and the registered handle memory read set these steps.
// reset clears the valid bits, ranks and count at once; no clearing pass.
// a stalled output holds its result while the next request may be accepted.
`default_nettype none

module keyed_cache_insert_order_evict #(
  parameter int unsigned ENTRIES     = kcio_pkg::ENTRIES_DEF,
  parameter int unsigned HANDLE_BITS = kcio_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [kcio_pkg::MODE_BITS-1:0]  mode_i,
  input  wire logic [kcio_pkg::KEY_BITS-1:0]   key_i,
  input  wire logic [kcio_pkg::VALUE_BITS-1:0] store_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 hit_o,
  output logic      [kcio_pkg::VALUE_BITS-1:0] read_value_o,
  output logic                                 evicted_o,
  output logic      [kcio_pkg::KEY_BITS-1:0]   evicted_key_o,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [kcio_pkg::APB_AW-1:0]     paddr,
  input  wire logic [kcio_pkg::APB_DW-1:0]     pwdata,
  output logic      [kcio_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready
);

  import kcio_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [LIMIT_BITS-1:0] max_entries_q;
  logic                  cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
    end else if (cfg_wr && (paddr[2] == REG_MAX_ENTRIES)) begin
      max_entries_q <= pwdata[LIMIT_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? APB_DW'(max_entries_q) : '0;

  // controller
  kcio_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  kcio_dp #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .max_entries_i (max_entries_q),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .store_value_i (store_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  // one request in flight: an accepted request blocks the next one
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("request accepted while previous one still in flight");

  // a result is only handed over when the output register can take it
  a_deliver_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.deliver |-> sts.out_free
  ) else $error("result handed over onto a stalled output");

  // a new result appears only after a hand-over
  a_out_from_deliver: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.deliver)
  ) else $error("output valid without a hand-over");

  // the controller issues at most one command per cycle
  a_cmd_onehot: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.look, cmd.exec, cmd.deliver})
  ) else $error("more than one datapath command at once");

endmodule : keyed_cache_insert_order_evict

`default_nettype wire

>>> rtl/core/kcio_ram.sv
// generic single write port ram with registered read
`default_nettype none

module kcio_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : kcio_ram

`default_nettype wire

>>> rtl/core/kcio_ctrl.sv
// sequencing state machine for the keyed cache
`default_nettype none

module kcio_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire kcio_pkg::dp_sts_t sts_i,
  output kcio_pkg::dp_cmd_t      cmd_o
);

  import kcio_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_EXEC;
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command decode
  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.look    = (state_q == ST_LOOK);
    cmd_o.exec    = (state_q == ST_EXEC);
    cmd_o.deliver = (state_q == ST_RESP) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule : kcio_ctrl

`default_nettype wire

>>> rtl/core/kcio_dp.sv
// key table, recency ranks, handle memory and result register
`default_nettype none

module kcio_dp #(
  parameter int unsigned ENTRIES     = kcio_pkg::ENTRIES_DEF,
  parameter int unsigned HANDLE_BITS = kcio_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire kcio_pkg::dp_cmd_t                   cmd_i,
  output kcio_pkg::dp_sts_t                        sts_o,
  input  wire logic [kcio_pkg::LIMIT_BITS-1:0]     max_entries_i,
  input  wire logic [kcio_pkg::MODE_BITS-1:0]      mode_i,
  input  wire logic [kcio_pkg::KEY_BITS-1:0]       key_i,
  input  wire logic [kcio_pkg::VALUE_BITS-1:0]     store_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     hit_o,
  output logic      [kcio_pkg::VALUE_BITS-1:0]     read_value_o,
  output logic                                     evicted_o,
  output logic      [kcio_pkg::KEY_BITS-1:0]       evicted_key_o
);

  import kcio_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  // captured request
  logic [MODE_BITS-1:0]   op_mode_q;
  logic [KEY_BITS-1:0]    op_key_q;
  logic [HANDLE_BITS-1:0] op_val_q;

  // table state
  logic [KEY_BITS-1:0] key_q   [ENTRIES];
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [IW-1:0]       rank_q  [ENTRIES];
  logic [IW-1:0]       rank_d  [ENTRIES];
  logic [CW-1:0]       count_q, count_d;

  // lookup results
  logic          hit_q, evict_need_q;
  logic [IW-1:0] hit_idx_q, old_idx_q;

  // staged result
  logic                res_hit_q, res_get_q, res_evict_q;
  logic [KEY_BITS-1:0] res_evk_q;

  // output register
  logic                  out_valid_q;
  logic                  out_hit_q, out_evict_q;
  logic [VALUE_BITS-1:0] out_read_q;
  logic [KEY_BITS-1:0]   out_evk_q;

  // handle memory ports
  logic                   ram_we, ram_re;
  logic [IW-1:0]          ram_waddr;
  logic [HANDLE_BITS-1:0] ram_rdata;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_mode_q <= mode_i;
      op_key_q  <= key_i;
      op_val_q  <= HANDLE_BITS'(store_value_i);
    end
  end

  // effective capacity limit
  logic [LW-1:0] limit_w;
  always_comb begin
    limit_w = LW'(max_entries_i);
    if (max_entries_i == '0) begin
      limit_w = LW'(1);
    end else if (LW'(max_entries_i) > LW'(ENTRIES)) begin
      limit_w = LW'(ENTRIES);
    end
  end

  // parallel key compare and oldest entry search
  logic [ENTRIES-1:0] match_w, oldest_w;
  logic [IW-1:0]      match_idx_w, old_idx_w;
  logic [CW-1:0]      count_m1_w;
  assign count_m1_w = count_q - CW'(1);

  always_comb begin
    match_idx_w = '0;
    old_idx_w   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_w[i]  = valid_q[i] && (key_q[i] == op_key_q);
      oldest_w[i] = valid_q[i] && (CW'(rank_q[i]) == count_m1_w);
      match_idx_w = match_idx_w | (match_w[i] ? IW'(i) : '0);
      old_idx_w   = old_idx_w | (oldest_w[i] ? IW'(i) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      hit_q        <= |match_w;
      hit_idx_q    <= match_idx_w;
      old_idx_q    <= old_idx_w;
      evict_need_q <= (LW'(count_q) >= limit_w) && (count_q != '0);
    end
  end

  // free slot after a possible eviction
  logic               is_set_w, is_get_w, do_evict_w, found_w;
  logic [ENTRIES-1:0] old_oh_w, kept_w, free_w, free_oh_w;
  logic [IW-1:0]      free_idx_w, hit_rank_w;

  assign is_set_w   = (op_mode_q == MODE_SET);
  assign is_get_w   = (op_mode_q == MODE_GET);
  assign do_evict_w = is_set_w && !hit_q && evict_need_q;
  assign old_oh_w   = ENTRIES'(1) << old_idx_q;
  assign kept_w     = valid_q & ~(do_evict_w ? old_oh_w : '0);
  assign free_w     = ~kept_w;
  assign free_oh_w  = free_w & (~free_w + ENTRIES'(1));
  assign found_w    = |free_w;
  assign hit_rank_w = rank_q[hit_idx_q];

  always_comb begin
    free_idx_w = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      free_idx_w = free_idx_w | (free_oh_w[i] ? IW'(i) : '0);
    end
  end

  // table update
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.exec) begin
      case (op_mode_q)
        MODE_SET: begin
          if (hit_q) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_q[i] && (rank_q[i] < hit_rank_w)) begin
                rank_d[i] = rank_q[i] + IW'(1);
              end
            end
            rank_d[hit_idx_q] = '0;
          end else begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (kept_w[i]) begin
                rank_d[i] = rank_q[i] + IW'(1);
              end else if (do_evict_w && old_oh_w[i]) begin
                rank_d[i] = '0;
              end
            end
            if (found_w) begin
              rank_d[free_idx_w] = '0;
            end
            valid_d = kept_w | (found_w ? free_oh_w : '0);
            count_d = count_q - CW'(do_evict_w) + CW'(found_w);
          end
        end
        MODE_CLEAR: begin
          valid_d = '0;
          count_d = '0;
          for (int i = 0; i < ENTRIES; i++) begin
            rank_d[i] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // key write for a new entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && is_set_w && !hit_q && found_w) begin
      key_q[free_idx_w] <= op_key_q;
    end
  end

  // handle memory access
  assign ram_we    = cmd_i.exec && is_set_w && (hit_q || found_w);
  assign ram_waddr = hit_q ? hit_idx_q : free_idx_w;
  assign ram_re    = cmd_i.exec && is_get_w && hit_q;

  kcio_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (ENTRIES)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (op_val_q),
    .re_i    (ram_re),
    .raddr_i (hit_idx_q),
    .rdata_o (ram_rdata)
  );

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_hit_q   <= (is_get_w || is_set_w) && hit_q;
      res_get_q   <= is_get_w && hit_q;
      res_evict_q <= do_evict_w;
      res_evk_q   <= do_evict_w ? key_q[old_idx_q] : '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.deliver) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deliver) begin
      out_hit_q   <= res_hit_q;
      out_read_q  <= res_get_q ? VALUE_BITS'(ram_rdata) : '0;
      out_evict_q <= res_evict_q;
      out_evk_q   <= res_evk_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign read_value_o  = out_read_q;
  assign evicted_o     = out_evict_q;
  assign evicted_key_o = out_evk_q;

endmodule : kcio_dp

`default_nettype wire

>>> bench/tb_keyed_cache_insert_order_evict.sv
// testbench for the keyed cache with insert-order eviction and a capacity limit
module tb_keyed_cache_insert_order_evict;
  timeunit 1ns;
  timeprecision 1ps;
  import kcio_pkg::*;

  localparam int unsigned SLOTS = ENTRIES_DEF;
  localparam int unsigned RANK_BITS = $clog2(SLOTS);
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_MAX_ENTRIES = {REG_MAX_ENTRIES, 2'b00};
  localparam int unsigned SEGMENTS = 8;
  localparam int unsigned SEGMENT_REQUESTS = 130;
  localparam int unsigned POOL_SIZE = 32;
  localparam int unsigned SETTLE_CYCLES = 12;

  localparam logic [KEY_BITS-1:0] KEY_ZERO = '0;
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;
  localparam logic [KEY_BITS-1:0] KEY_A = 64'h0123_4567_89ab_cdef;
  localparam logic [KEY_BITS-1:0] KEY_B = 64'hfedc_ba98_7654_3210;
  localparam logic [KEY_BITS-1:0] KEY_C = 64'h8000_0000_0000_0001;
  localparam logic [KEY_BITS-1:0] KEY_D = 64'h5a5a_a5a5_3c3c_c3c3;
  localparam logic [KEY_BITS-1:0] KEY_E = 64'h7fff_ffff_ffff_fffe;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } cache_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [MODE_BITS-1:0]  mode_i;
  logic [KEY_BITS-1:0]   key_i;
  logic [VALUE_BITS-1:0] store_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [VALUE_BITS-1:0] read_value_o;
  logic                  evicted_o;
  logic [KEY_BITS-1:0]   evicted_key_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  // mirror of the cache contents
  logic [KEY_BITS-1:0]   shadow_keys    [SLOTS];
  logic [VALUE_BITS-1:0] shadow_handles [SLOTS];
  bit                    shadow_live    [SLOTS];
  bit [RANK_BITS-1:0]    shadow_rank    [SLOTS];
  bit [LIMIT_BITS-1:0]   shadow_count;
  bit [LIMIT_BITS-1:0]   shadow_limit;

  cache_result_t         pending_results [$];
  logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
  int unsigned           fail_count = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;

  keyed_cache_insert_order_evict dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .store_value_i (store_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always #5ns clk_i = ~clk_i;

  // random back-pressure on the result side
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // apply one request to the mirror and return the result it should give
  function automatic cache_result_t apply_cache_op(input logic [MODE_BITS-1:0] op,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [VALUE_BITS-1:0] value);
    cache_result_t      res;
    int                 found;
    int                 oldest;
    int                 spare;
    bit [LIMIT_BITS-1:0] cap;
    bit [RANK_BITS-1:0] old_rank;
    res = '0;
    found = -1;
    oldest = -1;
    spare = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_live[i] && shadow_keys[i] == key && found < 0) found = i;
    end
    // zero acts as one, anything above the table size saturates
    if (shadow_limit == 0) cap = LIMIT_BITS'(1);
    else if (shadow_limit > SLOTS) cap = LIMIT_BITS'(SLOTS);
    else cap = shadow_limit;
    case (op)
      MODE_GET: begin
        if (found >= 0) begin
          res.hit = 1'b1;
          res.read_value = shadow_handles[found];
        end
      end
      MODE_SET: begin
        if (found >= 0) begin
          // overwrite in place and move to newest, no eviction
          old_rank = shadow_rank[found];
          res.hit = 1'b1;
          for (int i = 0; i < SLOTS; i++) begin
            if (shadow_live[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
          end
          shadow_rank[found] = '0;
          shadow_handles[found] = value;
        end else begin
          // at or above the limit: drop the single oldest entry
          if (shadow_count >= cap && shadow_count > 0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (shadow_live[i] && (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]))
                oldest = i;
            end
            if (oldest >= 0) begin
              res.evicted = 1'b1;
              res.evicted_key = shadow_keys[oldest];
              shadow_live[oldest] = 1'b0;
              shadow_rank[oldest] = '0;
              shadow_count--;
            end
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (!shadow_live[i] && spare < 0) spare = i;
          end
          if (spare >= 0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (shadow_live[i]) shadow_rank[i]++;
            end
            shadow_live[spare] = 1'b1;
            shadow_keys[spare] = key;
            shadow_handles[spare] = value;
            shadow_rank[spare] = '0;
            shadow_count++;
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          shadow_live[i] = 1'b0;
          shadow_rank[i] = '0;
        end
        shadow_count = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // send one request, with a random idle gap in front of it
  task automatic send_request(input logic [MODE_BITS-1:0] op,
                              input logic [KEY_BITS-1:0] key,
                              input logic [VALUE_BITS-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    mode_i <= op;
    key_i <= key;
    store_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_cache_op(op, key, value));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // write the capacity limit through the register port while idle
  task automatic write_limit(input int unsigned limit);
    drain_requests();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_ENTRIES;
    pwdata <= APB_DW'(limit);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_limit = LIMIT_BITS'(limit);
  endtask

  // extreme keys and handles, overwrite, the spare mode and clear
  task automatic test_basic_ops();
    send_request(MODE_GET, KEY_ZERO, 32'h1234_5678);
    send_request(MODE_SET, KEY_ZERO, 32'hffff_ffff);
    send_request(MODE_SET, KEY_ONES, 32'h0000_0000);
    send_request(MODE_GET, KEY_ZERO, 32'h0000_0000);
    send_request(MODE_GET, KEY_ONES, 32'hffff_ffff);
    send_request(MODE_SET, KEY_ZERO, 32'ha5a5_5a5a);
    send_request(MODE_GET, KEY_ZERO, 32'h0000_0000);
    send_request(MODE_SPARE, KEY_ZERO, 32'hffff_ffff);
    send_request(MODE_GET, KEY_ZERO, 32'h0000_0000);
    send_request(MODE_CLEAR, KEY_ONES, 32'hffff_ffff);
    send_request(MODE_GET, KEY_ZERO, 32'h0000_0000);
  endtask

  // a limit of zero behaves as one, a limit above the table saturates
  task automatic test_limit_extremes();
    write_limit(0);
    send_request(MODE_SET, KEY_A, 32'h0000_0001);
    send_request(MODE_SET, KEY_B, 32'h0000_0002);
    send_request(MODE_GET, KEY_A, 32'h0000_0000);
    write_limit(31);
    send_request(MODE_SET, KEY_C, 32'h0000_0003);
  endtask

  // limit lowered under the count: each new key evicts only one entry
  task automatic test_limit_lowered();
    write_limit(1);
    send_request(MODE_SET, KEY_D, 32'h0000_0004);
    send_request(MODE_SET, KEY_E, 32'h0000_0005);
    send_request(MODE_GET, KEY_D, 32'h0000_0000);
  endtask

  // random traffic over several limits and idling patterns
  task automatic test_random_traffic();
    int unsigned          limits [SEGMENTS];
    int unsigned          key_span;
    int unsigned          pick;
    logic [MODE_BITS-1:0] op;
    logic [KEY_BITS-1:0]  key;
    limits = '{16, 1, 31, 0, 17, $urandom_range(31), $urandom_range(2, 15), 16};
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_limit(limits[seg]);
      // idling phases: none, sender only, receiver only, both
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      key_pool[0] = KEY_ZERO;
      key_pool[1] = KEY_ONES;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      key_span = $urandom_range(4, POOL_SIZE);
      for (int n = 0; n < SEGMENT_REQUESTS; n++) begin
        pick = $urandom_range(99);
        if (pick < 47) op = MODE_GET;
        else if (pick < 98) op = MODE_SET;
        else if (pick < 99) op = MODE_CLEAR;
        else op = MODE_SPARE;
        // mostly keys from a small pool so that hits and evictions occur
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(key_span - 1)];
        else key = {$urandom, $urandom};
        send_request(op, key, $urandom);
      end
    end
  endtask

  // compare each delivered result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    cache_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result delivered with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0h, got %0h", want.hit, hit_o);
          fail_count++;
        end
        if (read_value_o !== want.read_value) begin
          $error("read_value: expected %0h, got %0h", want.read_value, read_value_o);
          fail_count++;
        end
        if (evicted_o !== want.evicted) begin
          $error("evicted: expected %0h, got %0h", want.evicted, evicted_o);
          fail_count++;
        end
        if (evicted_key_o !== want.evicted_key) begin
          $error("evicted_key: expected %0h, got %0h", want.evicted_key, evicted_key_o);
          fail_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    mode_i <= MODE_GET;
    key_i <= '0;
    store_value_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_live[i] = 1'b0;
      shadow_rank[i] = '0;
    end
    shadow_count = '0;
    shadow_limit = MAX_ENTRIES_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_limit_extremes();
    test_limit_lowered();
    test_random_traffic();

    // let the last results out, then watch for strays
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never delivered", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_keyed_cache_insert_order_evict OK");
    end else begin
      $display("tb_keyed_cache_insert_order_evict NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("tb_keyed_cache_insert_order_evict NOT OK");
    $finish;
  end

endmodule

>>> keyed_cache_insert_order_evict.f
rtl/core/kcio_pkg.sv
rtl/core/kcio_ram.sv
rtl/core/kcio_ctrl.sv
rtl/core/kcio_dp.sv
rtl/core/keyed_cache_insert_order_evict.sv
bench/tb_keyed_cache_insert_order_evict.sv
